// ----- hdl/wua_pkg.sv -----
// Shared declarations for the wide unsigned arithmetic unit.
// Holds operation codes, sequencer state and control types and sizing constants.
// Depends on nothing.
package wua_pkg;

  localparam int unsigned Width    = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned ShamtW   = 8;
  localparam int unsigned OpW      = 3;
  localparam int unsigned StepCntW = $clog2(Width);

  typedef logic [Width-1:0] word_t;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_SHL = 3'd4,
    OP_SHR = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_e;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

endpackage

// ----- hdl/wua_alu.sv -----
// Shared arithmetic unit: one 128-bit adder/subtractor and one barrel shifter.
// Purely combinational; uses wua_pkg.
module wua_alu (
  input  wua_pkg::word_t                   x_i,
  input  wua_pkg::word_t                   y_i,
  input  logic                             sub_i,
  input  wua_pkg::word_t                   sh_val_i,
  input  logic [wua_pkg::ShamtW-1:0]       sh_amt_i,
  input  logic                             sh_left_i,
  output wua_pkg::word_t                   sum_o,
  output logic                             cout_o,
  output wua_pkg::word_t                   sh_res_o,
  output logic                             sh_flag_o
);
  import wua_pkg::*;

  logic [Width:0] sum_w;
  logic [Width:0] shl_w;
  logic [Width:0] shr_w;
  word_t          y_inv;

  // Subtraction is x + ~y + 1, so the carry out is the inverse of the borrow.
  assign y_inv = sub_i ? ~y_i : y_i;
  assign sum_w = {1'b0, x_i} + {1'b0, y_inv} + {{Width{1'b0}}, sub_i};
  assign sum_o  = sum_w[Width-1:0];
  assign cout_o = sum_w[Width];

  // One guard bit catches the last bit shifted out on either side.
  assign shl_w = {1'b0, sh_val_i} << sh_amt_i;
  assign shr_w = {sh_val_i, 1'b0} >> sh_amt_i;

  assign sh_res_o  = sh_left_i ? shl_w[Width-1:0] : shr_w[Width:1];
  assign sh_flag_o = sh_left_i ? shl_w[Width]     : shr_w[0];

endmodule

// ----- hdl/wua_seq.sv -----
// Sequencer of the wide unsigned arithmetic unit: state machine and step counter.
// Uses wua_pkg for the state enum and the control struct.
module wua_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           multi_i,
  input  logic           slot_free_i,
  output logic           in_ready_o,
  output wua_pkg::ctrl_t ctrl_o
);
  import wua_pkg::*;

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          cnt_d       = '0;
          state_d     = ST_STEP;
        end
      end
      ST_STEP: begin
        ctrl_o.step = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        // Long operations make one pass per operand bit.
        if (!multi_i || (cnt_q == {StepCntW{1'b1}})) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/wide_unsigned_arithmetic_unit_top.sv -----
// Top level of the 128-bit wide unsigned arithmetic unit.
// Instantiates wua_seq and wua_alu and holds the operand and output registers; uses wua_pkg.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         in_valid_i / in_ready_o    req_type, first_*, second_*, shift_amount
//   result    out        out_valid_o / out_ready_i  result_*, remainder_*, flag_out, zero_divisor
//
// Add, subtract, shift, unused codes and divide by zero make one pass through the
// shared unit and then load the output register, which offers the result; the load
// waits while an earlier result in the output register has not been taken. The
// request side is ready again once the output register has been loaded.
// Multiply and divide make one pass through the shared 128-bit adder per operand bit
// (shift-and-add, restoring division) before the output register is loaded.
// Reset clears the sequencer and the output valid flag; no request is taken until
// the current one has been loaded into the output register.
// A new request is accepted while a finished result still waits to be taken.
module wide_unsigned_arithmetic_unit_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wua_pkg::OpW-1:0]        req_type_i,
  input  logic [wua_pkg::HalfW-1:0]      first_hi_i,
  input  logic [wua_pkg::HalfW-1:0]      first_lo_i,
  input  logic [wua_pkg::HalfW-1:0]      second_hi_i,
  input  logic [wua_pkg::HalfW-1:0]      second_lo_i,
  input  logic [wua_pkg::ShamtW-1:0]     shift_amount_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wua_pkg::HalfW-1:0]      result_hi_o,
  output logic [wua_pkg::HalfW-1:0]      result_lo_o,
  output logic [wua_pkg::HalfW-1:0]      remainder_hi_o,
  output logic [wua_pkg::HalfW-1:0]      remainder_lo_o,
  output logic                           flag_out_o,
  output logic                           zero_divisor_o
);
  import wua_pkg::*;

  // Working registers. For divide, a_q is the dividend shifting out while the
  // quotient shifts in, and acc_q is the partial remainder. For multiply,
  // a_q is the multiplicand moving left, b_q the multiplier moving right and
  // acc_q the running product. Every other operation leaves its answer in acc_q.
  op_e                 op_q;
  word_t               a_q, a_d;
  word_t               b_q, b_d;
  word_t               acc_q, acc_d;
  logic [ShamtW-1:0]   shamt_q;
  logic                flag_q, flag_d;
  logic                zdiv_q;

  // Output register.
  logic                out_valid_q;
  word_t               res_out_q;
  word_t               rem_out_q;
  logic                flag_out_q;
  logic                zdiv_out_q;

  ctrl_t               ctrl;
  logic                multi;
  logic                slot_free;

  word_t               alu_x, alu_y, alu_sum, sh_res;
  logic                alu_sub, alu_cout, sh_flag;
  logic                div_ge;

  assign multi     = (op_q == OP_MUL) || ((op_q == OP_DIV) && !zdiv_q);
  assign slot_free = !out_valid_q || out_ready_i;

  wua_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .multi_i     (multi),
    .slot_free_i (slot_free),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  // Operand routing into the shared adder.
  always_comb begin
    alu_x   = a_q;
    alu_y   = b_q;
    alu_sub = 1'b0;
    case (op_q)
      OP_SUB: begin
        alu_sub = 1'b1;
      end
      OP_MUL: begin
        alu_x = acc_q;
        alu_y = a_q;
      end
      OP_DIV: begin
        alu_x   = {acc_q[Width-2:0], a_q[Width-1]};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  wua_alu u_alu (
    .x_i       (alu_x),
    .y_i       (alu_y),
    .sub_i     (alu_sub),
    .sh_val_i  (a_q),
    .sh_amt_i  (shamt_q),
    .sh_left_i (op_q == OP_SHL),
    .sum_o     (alu_sum),
    .cout_o    (alu_cout),
    .sh_res_o  (sh_res),
    .sh_flag_o (sh_flag)
  );

  // The remainder bit shifted past the top means it already exceeds the divisor.
  assign div_ge = acc_q[Width-1] | alu_cout;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    flag_d = flag_q;
    case (op_q)
      OP_ADD: begin
        acc_d  = alu_sum;
        flag_d = alu_cout;
      end
      OP_SUB: begin
        acc_d  = alu_sum;
        flag_d = !alu_cout;
      end
      OP_MUL: begin
        if (b_q[0]) begin
          acc_d = alu_sum;
        end
        a_d = {a_q[Width-2:0], 1'b0};
        b_d = {1'b0, b_q[Width-1:1]};
      end
      OP_DIV: begin
        if (zdiv_q) begin
          acc_d = a_q;
          a_d   = '0;
        end else begin
          acc_d = div_ge ? alu_sum : alu_x;
          a_d   = {a_q[Width-2:0], div_ge};
        end
      end
      OP_SHL, OP_SHR: begin
        acc_d  = sh_res;
        flag_d = sh_flag;
      end
      default: begin
        acc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      op_q    <= op_e'(req_type_i);
      a_q     <= {first_hi_i, first_lo_i};
      b_q     <= {second_hi_i, second_lo_i};
      acc_q   <= '0;
      shamt_q <= shift_amount_i;
      flag_q  <= 1'b0;
      zdiv_q  <= (op_e'(req_type_i) == OP_DIV) && ({second_hi_i, second_lo_i} == '0);
    end else if (ctrl.step) begin
      a_q    <= a_d;
      b_q    <= b_d;
      acc_q  <= acc_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      if (op_q == OP_DIV) begin
        res_out_q <= a_q;
        rem_out_q <= acc_q;
      end else begin
        res_out_q <= acc_q;
        rem_out_q <= '0;
      end
      flag_out_q <= flag_q;
      zdiv_out_q <= zdiv_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_hi_o    = res_out_q[Width-1:HalfW];
  assign result_lo_o    = res_out_q[HalfW-1:0];
  assign remainder_hi_o = rem_out_q[Width-1:HalfW];
  assign remainder_lo_o = rem_out_q[HalfW-1:0];
  assign flag_out_o     = flag_out_q;
  assign zero_divisor_o = zdiv_out_q;

`ifndef NO_ASSERTIONS
  // A transfer on the request side always makes the unit busy.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request side still ready after a request transfer");

  // A result is only offered after the sequencer has finished an operation.
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl.finish))
    else $error("result offered without a finished operation");

  // Division by zero gives a zero quotient.
  a_zdiv_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_divisor_o) |-> ((result_hi_o == '0) && (result_lo_o == '0)))
    else $error("non-zero quotient on division by zero");

  // Carry, borrow and shift-out never accompany a zero divisor report.
  a_flag_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(flag_out_o && zero_divisor_o))
    else $error("flag and zero divisor set together");
`endif

endmodule
